/* rtl/assert_macros.svh */
// ----------------------------------------------------------------------------
// assert_macros.svh
// assertion macros used by the checker file
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled in reset
`define TIC_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("triangle incircle check failed");

// next-cycle implication, disabled in reset
`define TIC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("triangle incircle check failed");

`endif

/* rtl/tic_pkg.sv */
// ----------------------------------------------------------------------------
// tic_pkg
// shared constants of the triangle incircle block
// ----------------------------------------------------------------------------
package tic_pkg;

    localparam int NUM_COORDS = 9;
    localparam int NUM_CENTER = 3;
    localparam int CENTROID_DIV = 3;

    localparam logic MODE_CENTROID = 1'b0;
    localparam logic MODE_INCENTER = 1'b1;

endpackage

/* rtl/triangle_incircle_core.sv */
// ----------------------------------------------------------------------------
// triangle_incircle_core
// incentre (or centroid z, by mode) and inradius of one 3D triangle per cycle unless stalled, Heron form
// ----------------------------------------------------------------------------
// usage
//   s_t* carries one triangle (nine signed coordinates) per transfer,
//   m_t* returns one result per triangle in the same order; m_tuser flags a
//   zero perimeter, in which case all of m_tdata is zero.
//   cfg_we/cfg_wdata write the centre-z mode (1 incentre z, 0 centroid z);
//   write it only while no triangle is in flight.
// throughput
//   one triangle per cycle while no result waits on m_tready; the path is
//   edge square roots, the radius divider and the radius square root, all
//   pipelined one bit per stage.
// reset
//   clears every stage valid bit and sets the mode to incentre z.
// stall
//   the whole pipeline holds while a result waits on m_tready; s_tready
//   drops in the same cycle and rises again as soon as the result is taken.
// ----------------------------------------------------------------------------
module triangle_incircle_core #(
    parameter int COORD_WIDTH = 32,
    localparam int IN_PAD  = ((tic_pkg::NUM_COORDS * COORD_WIDTH + 7) / 8) * 8,
    localparam int OUT_PAD = ((tic_pkg::NUM_CENTER * COORD_WIDTH + COORD_WIDTH - 1 + 7) / 8) * 8
)(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               s_tvalid,
    output logic               s_tready,
    // vertex_a_x, vertex_a_y, vertex_a_z, vertex_b_x .. vertex_c_z, zero pad
    input  logic [IN_PAD-1:0]  s_tdata,
    output logic               m_tvalid,
    input  logic               m_tready,
    // center_x, center_y, center_z, inradius, zero pad
    output logic [OUT_PAD-1:0] m_tdata,
    // degenerate
    output logic [0:0]         m_tuser,
    input  logic               cfg_we,
    input  logic               cfg_wdata
);

    localparam int W    = COORD_WIDTH;
    localparam int IN_W = tic_pkg::NUM_COORDS * W;
    localparam int EW   = W + 1;
    localparam int PW   = W + 3;
    localparam int FW   = W + 2;
    localparam int CW   = W + 2;
    localparam int PRW  = 2 * W + 2;
    localparam int SW   = 2 * W + 4;
    localparam int NUMC = SW + 1;
    localparam int NUMR = 3 * FW;
    localparam int DENR = PW + 2;
    localparam int E    = W + 4;
    localparam int T    = E + 4 + 3 * W;
    localparam int N    = T + 1;

    localparam int P_IDX  [3] = '{2, 0, 1};
    localparam int Q_IDX  [3] = '{1, 2, 0};
    localparam int O1_IDX [3] = '{1, 0, 0};
    localparam int O2_IDX [3] = '{2, 2, 1};

    logic         ce;
    logic [N-1:0] vld_reg;
    logic [N-1:0] vld_next;
    logic         mode_reg;

    logic signed [W-1:0] vin [9];
    logic signed [W-1:0] vc  [9];
    logic [IN_W-1:0]     coord_e;

    logic [W-1:0]       absd_reg  [3][3];
    logic [W-1:0]       absd_next [3][3];
    logic [2*W-1:0]     sq_reg    [3][3];
    logic [2*W-1:0]     sq_next   [3][3];
    logic [2*W+1:0]     e2_reg    [3];
    logic [2*W+1:0]     e2_next   [3];
    logic [EW-1:0]      edge_len  [3];

    logic [PW-1:0]          per_reg;
    logic [PW-1:0]          per_next;
    logic [FW-1:0]          fac_reg  [3];
    logic [FW-1:0]          fac_next [3];
    logic signed [PRW-1:0]  prod_reg  [3][3];
    logic signed [PRW-1:0]  prod_next [3][3];
    logic signed [CW-1:0]   csum_reg;
    logic signed [CW-1:0]   csum_next;

    logic signed [SW-1:0]   wsum_reg  [3];
    logic signed [SW-1:0]   wsum_next [3];
    logic [2*FW-1:0]        xy_reg;
    logic [2*FW-1:0]        xy_next;
    logic [FW-1:0]          z2_reg;
    logic [PW-1:0]          per2_reg;
    logic                   deg2_reg;
    logic                   deg2_next;
    logic [CW-1:0]          cabs_reg;
    logic [CW-1:0]          cabs_next;
    logic                   csign2_reg;

    logic [NUMC-1:0]        cnum_reg  [3];
    logic [NUMC-1:0]        cnum_next [3];
    logic [PW-1:0]          cden_reg  [3];
    logic [PW-1:0]          cden_next [3];
    logic [2:0]             csign_reg;
    logic [2:0]             csign_next;
    logic [2*FW-1:0]        lo_reg;
    logic [2*FW-1:0]        lo_next;
    logic [2*FW-1:0]        hi_reg;
    logic [2*FW-1:0]        hi_next;
    logic [PW-1:0]          per3_reg;
    logic                   deg3_reg;

    logic [NUMR-1:0]        rnum_reg;
    logic [NUMR-1:0]        rnum_next;
    logic [DENR-1:0]        rden_reg;

    logic [W:0]             cq [3];
    logic [2:0]             csign_d;
    logic [3*W-1:0]         cval;
    logic [3*W-1:0]         cfin;
    logic                   deg_t;
    logic [2*W-1:0]         rq;
    logic [W-1:0]           root;
    logic [W-2:0]           rad_sat;

    logic [OUT_PAD-1:0]     out_data_reg;
    logic [OUT_PAD-1:0]     out_data_next;
    logic                   out_deg_reg;

    // whole pipeline advances while the output register is free
    assign ce       = !vld_reg[N-1] || m_tready;
    assign s_tready = ce;
    assign vld_next = {vld_reg[N-2:0], s_tvalid};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg  <= '0;
            mode_reg <= tic_pkg::MODE_INCENTER;
        end
        else
        begin
            if (ce)
            begin
                vld_reg <= vld_next;
            end
            if (cfg_we)
            begin
                mode_reg <= cfg_wdata;
            end
        end
    end

    always_comb
    begin
        for (int k = 0; k < 9; k++)
        begin
            vin[k] = s_tdata[k*W +: W];
            vc[k]  = coord_e[k*W +: W];
        end
    end

    // edge differences, squares and sums
    always_comb
    begin : c_edge
        logic signed [W:0] d;
        for (int e = 0; e < 3; e++)
        begin
            for (int i = 0; i < 3; i++)
            begin
                d = (W+1)'(vin[P_IDX[e]*3+i]) - (W+1)'(vin[Q_IDX[e]*3+i]);
                absd_next[e][i] = d[W] ? W'(-d) : W'(d);
                sq_next[e][i]   = (2*W)'(absd_reg[e][i]) * (2*W)'(absd_reg[e][i]);
            end
            e2_next[e] = (2*W+2)'(sq_reg[e][0]) + (2*W+2)'(sq_reg[e][1])
                       + (2*W+2)'(sq_reg[e][2]);
        end
    end

    for (genvar e = 0; e < 3; e++)
    begin : g_edge
        tic_isqrt_pipe #(
            .ROOT_W (EW)
        ) u_sqrt (
            .clk      (clk),
            .ce       (ce),
            .radicand (e2_reg[e]),
            .root     (edge_len[e])
        );
    end

    tic_delay #(
        .WIDTH (IN_W),
        .DEPTH (E)
    ) u_coord_dly (
        .clk  (clk),
        .ce   (ce),
        .din  (s_tdata[IN_W-1:0]),
        .dout (coord_e)
    );

    // perimeter, clamped factors, weighted products
    always_comb
    begin : c_weight
        logic signed [W+3:0] f;
        per_next = PW'(edge_len[0]) + PW'(edge_len[1]) + PW'(edge_len[2]);
        for (int e = 0; e < 3; e++)
        begin
            f = $signed((W+4)'(edge_len[O1_IDX[e]])) + $signed((W+4)'(edge_len[O2_IDX[e]]))
              - $signed((W+4)'(edge_len[e]));
            fac_next[e] = f[W+3] ? '0 : f[FW-1:0];
        end
        for (int i = 0; i < 3; i++)
        begin
            for (int v = 0; v < 3; v++)
            begin
                prod_next[i][v] = PRW'(vc[v*3+i]) * PRW'($signed({1'b0, edge_len[v]}));
            end
        end
        csum_next = CW'(vc[2]) + CW'(vc[5]) + CW'(vc[8]);
    end

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            wsum_next[i] = SW'(prod_reg[i][0]) + SW'(prod_reg[i][1]) + SW'(prod_reg[i][2]);
        end
        xy_next   = (2*FW)'(fac_reg[0]) * (2*FW)'(fac_reg[1]);
        deg2_next = (per_reg == '0);
        cabs_next = (csum_reg[CW-1] ? CW'(-csum_reg) : CW'(csum_reg)) + CW'(1);
    end

    // divider operands, rounding offset folded into the numerator
    always_comb
    begin : c_numer
        logic [SW-1:0] m;
        for (int i = 0; i < 3; i++)
        begin
            m             = wsum_reg[i][SW-1] ? SW'(-wsum_reg[i]) : SW'(wsum_reg[i]);
            cnum_next[i]  = NUMC'(m) + NUMC'(per2_reg >> 1);
            cden_next[i]  = per2_reg;
            csign_next[i] = wsum_reg[i][SW-1];
        end
        if (mode_reg == tic_pkg::MODE_CENTROID)
        begin
            cnum_next[2]  = NUMC'(cabs_reg);
            cden_next[2]  = PW'(tic_pkg::CENTROID_DIV);
            csign_next[2] = csign2_reg;
        end
        lo_next   = (2*FW)'(xy_reg[FW-1:0]) * (2*FW)'(z2_reg);
        hi_next   = (2*FW)'(xy_reg[2*FW-1:FW]) * (2*FW)'(z2_reg);
        rnum_next = NUMR'(lo_reg) + {hi_reg, {FW{1'b0}}};
    end

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            absd_reg   <= absd_next;
            sq_reg     <= sq_next;
            e2_reg     <= e2_next;
            per_reg    <= per_next;
            fac_reg    <= fac_next;
            prod_reg   <= prod_next;
            csum_reg   <= csum_next;
            wsum_reg   <= wsum_next;
            xy_reg     <= xy_next;
            z2_reg     <= fac_reg[2];
            per2_reg   <= per_reg;
            deg2_reg   <= deg2_next;
            cabs_reg   <= cabs_next;
            csign2_reg <= csum_reg[CW-1];
            cnum_reg   <= cnum_next;
            cden_reg   <= cden_next;
            csign_reg  <= csign_next;
            lo_reg     <= lo_next;
            hi_reg     <= hi_next;
            per3_reg   <= per2_reg;
            deg3_reg   <= deg2_reg;
            rnum_reg   <= rnum_next;
            rden_reg   <= {per3_reg, 2'b00};
            out_data_reg <= out_data_next;
            out_deg_reg  <= deg_t;
        end
    end

    for (genvar i = 0; i < 3; i++)
    begin : g_center
        tic_div_pipe #(
            .NUM_W  (NUMC),
            .DEN_W  (PW),
            .QUOT_W (W + 1)
        ) u_div (
            .clk  (clk),
            .ce   (ce),
            .num  (cnum_reg[i]),
            .den  (cden_reg[i]),
            .quot (cq[i])
        );

        assign cval[i*W +: W] = csign_d[i] ? W'(-cq[i]) : W'(cq[i]);
    end

    tic_delay #(
        .WIDTH (3),
        .DEPTH (W + 1)
    ) u_sign_dly (
        .clk  (clk),
        .ce   (ce),
        .din  (csign_reg),
        .dout (csign_d)
    );

    tic_delay #(
        .WIDTH (3 * W),
        .DEPTH (2 * W)
    ) u_center_dly (
        .clk  (clk),
        .ce   (ce),
        .din  (cval),
        .dout (cfin)
    );

    tic_delay #(
        .WIDTH (1),
        .DEPTH (3 * W + 1)
    ) u_deg_dly (
        .clk  (clk),
        .ce   (ce),
        .din  (deg3_reg),
        .dout (deg_t)
    );

    // squared radius, then its root
    tic_div_pipe #(
        .NUM_W  (NUMR),
        .DEN_W  (DENR),
        .QUOT_W (2 * W)
    ) u_rad_div (
        .clk  (clk),
        .ce   (ce),
        .num  (rnum_reg),
        .den  (rden_reg),
        .quot (rq)
    );

    tic_isqrt_pipe #(
        .ROOT_W (W)
    ) u_rad_sqrt (
        .clk      (clk),
        .ce       (ce),
        .radicand (rq),
        .root     (root)
    );

    assign rad_sat       = root[W-1] ? '1 : root[W-2:0];
    assign out_data_next = deg_t ? '0 : OUT_PAD'({rad_sat, cfin});

    assign m_tvalid = vld_reg[N-1];
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_deg_reg;

endmodule

/* rtl/tic_delay.sv */
// ----------------------------------------------------------------------------
// tic_delay
// stallable shift line that keeps side data in step with the pipeline
// ----------------------------------------------------------------------------
module tic_delay #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 1
)(
    input  logic             clk,
    input  logic             ce,
    input  logic [WIDTH-1:0] din,
    output logic [WIDTH-1:0] dout
);

    logic [WIDTH-1:0] line_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            line_reg[0] <= din;
            for (int i = 1; i < DEPTH; i++)
            begin
                line_reg[i] <= line_reg[i-1];
            end
        end
    end

    assign dout = line_reg[DEPTH-1];

endmodule

/* rtl/tic_isqrt_pipe.sv */
// ----------------------------------------------------------------------------
// tic_isqrt_pipe
// pipelined integer square root, one result bit per stage, floored
// ----------------------------------------------------------------------------
module tic_isqrt_pipe #(
    parameter int ROOT_W = 16
)(
    input  logic                  clk,
    input  logic                  ce,
    input  logic [2*ROOT_W-1:0]   radicand,
    output logic [ROOT_W-1:0]     root
);

    logic [ROOT_W+1:0]   rem_reg  [ROOT_W];
    logic [ROOT_W-1:0]   root_reg [ROOT_W];
    logic [2*ROOT_W-1:0] rad_reg  [ROOT_W];

    logic [ROOT_W+1:0]   rem_in   [ROOT_W];
    logic [ROOT_W-1:0]   root_in  [ROOT_W];
    logic [2*ROOT_W-1:0] rad_in   [ROOT_W];

    logic [ROOT_W+1:0]   rem_next  [ROOT_W];
    logic [ROOT_W-1:0]   root_next [ROOT_W];
    logic [2*ROOT_W-1:0] rad_next  [ROOT_W];

    always_comb
    begin
        rem_in[0]  = '0;
        root_in[0] = '0;
        rad_in[0]  = radicand;
        for (int k = 1; k < ROOT_W; k++)
        begin
            rem_in[k]  = rem_reg[k-1];
            root_in[k] = root_reg[k-1];
            rad_in[k]  = rad_reg[k-1];
        end
    end

    always_comb
    begin : c_stage
        logic [ROOT_W+1:0] rem_sh;
        logic [ROOT_W+1:0] trial;
        logic              fits;
        for (int k = 0; k < ROOT_W; k++)
        begin
            rem_sh       = {rem_in[k][ROOT_W-1:0], rad_in[k][2*ROOT_W-1 -: 2]};
            trial        = {root_in[k], 2'b01};
            fits         = (rem_sh >= trial);
            rem_next[k]  = fits ? (rem_sh - trial) : rem_sh;
            root_next[k] = {root_in[k][ROOT_W-2:0], fits};
            rad_next[k]  = {rad_in[k][2*ROOT_W-3:0], 2'b00};
        end
    end

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            rem_reg  <= rem_next;
            root_reg <= root_next;
            rad_reg  <= rad_next;
        end
    end

    assign root = root_reg[ROOT_W-1];

endmodule

/* rtl/tic_div_pipe.sv */
// ----------------------------------------------------------------------------
// tic_div_pipe
// pipelined restoring divider, one quotient bit per stage, floored
// ----------------------------------------------------------------------------
module tic_div_pipe #(
    parameter int NUM_W  = 16,
    parameter int DEN_W  = 8,
    parameter int QUOT_W = 8
)(
    input  logic              clk,
    input  logic              ce,
    input  logic [NUM_W-1:0]  num,
    input  logic [DEN_W-1:0]  den,
    output logic [QUOT_W-1:0] quot
);

    logic [DEN_W-1:0]  rem_reg  [QUOT_W];
    logic [DEN_W-1:0]  den_reg  [QUOT_W];
    logic [QUOT_W-1:0] low_reg  [QUOT_W];
    logic [QUOT_W-1:0] quot_reg [QUOT_W];

    logic [DEN_W-1:0]  rem_in  [QUOT_W];
    logic [DEN_W-1:0]  den_in  [QUOT_W];
    logic [QUOT_W-1:0] low_in  [QUOT_W];
    logic [QUOT_W-1:0] quot_in [QUOT_W];

    logic [DEN_W-1:0]  rem_next  [QUOT_W];
    logic [QUOT_W-1:0] low_next  [QUOT_W];
    logic [QUOT_W-1:0] quot_next [QUOT_W];

    // upper numerator bits are below the divisor for every operand pair in use
    always_comb
    begin
        rem_in[0]  = DEN_W'(num >> QUOT_W);
        den_in[0]  = den;
        low_in[0]  = num[QUOT_W-1:0];
        quot_in[0] = '0;
        for (int k = 1; k < QUOT_W; k++)
        begin
            rem_in[k]  = rem_reg[k-1];
            den_in[k]  = den_reg[k-1];
            low_in[k]  = low_reg[k-1];
            quot_in[k] = quot_reg[k-1];
        end
    end

    always_comb
    begin : c_stage
        logic [DEN_W:0] trial;
        logic           fits;
        for (int k = 0; k < QUOT_W; k++)
        begin
            trial        = {rem_in[k], low_in[k][QUOT_W-1]};
            fits         = (trial >= {1'b0, den_in[k]});
            rem_next[k]  = fits ? DEN_W'(trial - {1'b0, den_in[k]}) : trial[DEN_W-1:0];
            low_next[k]  = low_in[k] << 1;
            quot_next[k] = {quot_in[k][QUOT_W-2:0], fits};
        end
    end

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            rem_reg  <= rem_next;
            den_reg  <= den_in;
            low_reg  <= low_next;
            quot_reg <= quot_next;
        end
    end

    assign quot = quot_reg[QUOT_W-1];

endmodule

/* rtl/tic_checker.sv */
// ----------------------------------------------------------------------------
// tic_checker
// port-level assertions for the triangle incircle block, bound to the top
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module tic_checker #(
    parameter int COORD_WIDTH = 32,
    localparam int OUT_PAD = ((tic_pkg::NUM_CENTER * COORD_WIDTH + COORD_WIDTH - 1 + 7) / 8) * 8
)(
    input logic               clk,
    input logic               rst_n,
    input logic               s_tready,
    input logic               m_tvalid,
    input logic               m_tready,
    input logic [OUT_PAD-1:0] m_tdata,
    input logic [0:0]         m_tuser
);

    // a free output register means the input side is ready
    `TIC_ASSERT_IMP(a_ready_when_free, clk, rst_n, !m_tvalid || m_tready, s_tready)

    // a waiting result blocks the input side
    `TIC_ASSERT_IMP(a_stall_blocks_input, clk, rst_n, m_tvalid && !m_tready, !s_tready)

    `TIC_ASSERT_NEXT(a_result_held, clk, rst_n, m_tvalid && !m_tready,
                     m_tvalid && $stable(m_tdata) && $stable(m_tuser))

    // degenerate triangles give all-zero results
    `TIC_ASSERT_IMP(a_degenerate_zero, clk, rst_n, m_tvalid && m_tuser[0], m_tdata == '0)

endmodule

bind triangle_incircle_core tic_checker #(
    .COORD_WIDTH (COORD_WIDTH)
) u_tic_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
